[rtl/bptc_pkg.sv]
package bptc_pkg;

  localparam int RawW      = 24;
  localparam int CoeffW    = 16;
  localparam int CfgIdxW   = 3;
  localparam int NumStages = 10;

  // stage enables handed to each datapath module
  localparam int FrontFirst = 0;
  localparam int CorrFirst  = 3;
  localparam int PressFirst = 6;

  localparam logic [CfgIdxW-1:0] RegSensCoeff      = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOffsetCoeff    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSensTempCoeff  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOffsetTempCoeff = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRefTempCoeff   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTempSlopeCoeff = 3'd5;

  typedef struct packed {
    logic [RawW-1:0] raw_pressure;
    logic [RawW-1:0] raw_temperature;
  } in_t;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic [17:0]        pressure;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic [CoeffW-1:0] sens_coeff;
    logic [CoeffW-1:0] offset_coeff;
    logic [CoeffW-1:0] sens_temp_coeff;
    logic [CoeffW-1:0] offset_temp_coeff;
    logic [CoeffW-1:0] ref_temp_coeff;
    logic [CoeffW-1:0] temp_slope_coeff;
  } cfg_t;

  // first-order terms
  typedef struct packed {
    logic [RawW-1:0]    d1;
    logic signed [19:0] temp;
    logic signed [35:0] off;
    logic signed [34:0] sens;
    logic [17:0]        t2;
  } front_t;

  // corrected offset/sensitivity and finished temperature
  typedef struct packed {
    logic [RawW-1:0]    d1;
    logic signed [39:0] offc;
    logic signed [39:0] sensc;
    logic signed [15:0] temperature;
    logic               tsat;
  } corr_t;

endpackage

[rtl/baro_pressure_temp_compensation_top.sv]
// Second-order barometric compensation: each beat carries one raw 24-bit pressure
// and one raw 24-bit temperature conversion and yields the temperature in 0.01 degC
// and the pressure in Pa, both clipped to their output ranges with a saturated
// flag. A reading can enter every cycle unless stalls back up to the input; each
// result passes through the ten-stage multiply chain (dT products, squares for the
// cold correction, and the split D1 * SENS product). The output register and the
// per-stage valid bits let stalls fill bubbles without losing beats. The six
// calibration words are written through cfg_we_i/cfg_idx_i/cfg_wdata_i while no
// reading is in flight; ADC_BITS keeps only the low bits of each raw input.
module baro_pressure_temp_compensation_top #(
  parameter int ADC_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  bptc_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output bptc_pkg::out_t                    out_data_o,
  input  logic                              cfg_we_i,
  input  logic [bptc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [bptc_pkg::CoeffW-1:0]       cfg_wdata_i
);

  bptc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bptc_pkg::RegSensCoeff:       cfg_q.sens_coeff        <= cfg_wdata_i;
        bptc_pkg::RegOffsetCoeff:     cfg_q.offset_coeff      <= cfg_wdata_i;
        bptc_pkg::RegSensTempCoeff:   cfg_q.sens_temp_coeff   <= cfg_wdata_i;
        bptc_pkg::RegOffsetTempCoeff: cfg_q.offset_temp_coeff <= cfg_wdata_i;
        bptc_pkg::RegRefTempCoeff:    cfg_q.ref_temp_coeff    <= cfg_wdata_i;
        bptc_pkg::RegTempSlopeCoeff:  cfg_q.temp_slope_coeff  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [bptc_pkg::NumStages-1:0] en;
  bptc_pkg::front_t               front;
  bptc_pkg::corr_t                corr;

  bptc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .en_o        (en)
  );

  bptc_front #(
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .clk_i (clk_i),
    .en_i  (en[bptc_pkg::FrontFirst +: 3]),
    .in_i  (in_data_i),
    .cfg_i (cfg_q),
    .res_o (front)
  );

  bptc_corr u_corr (
    .clk_i   (clk_i),
    .en_i    (en[bptc_pkg::CorrFirst +: 3]),
    .front_i (front),
    .res_o   (corr)
  );

  bptc_press u_press (
    .clk_i  (clk_i),
    .en_i   (en[bptc_pkg::PressFirst +: 4]),
    .corr_i (corr),
    .res_o  (out_data_o)
  );

endmodule

[rtl/bptc_ctrl.sv]
module bptc_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic [bptc_pkg::NumStages-1:0]    en_o
);

  localparam int N = bptc_pkg::NumStages;

  logic [N-1:0] valid_q, valid_d;
  logic [N-1:0] ready;

  // a stage moves when it is empty or the stage after it moves
  always_comb begin
    ready[N-1] = !valid_q[N-1] || !out_stall_i;
    for (int k = N - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  always_comb begin
    valid_d[0] = ready[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < N; k++) begin
      valid_d[k] = ready[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign en_o        = ready;
  assign in_stall_o  = !ready[0];
  assign out_valid_o = valid_q[N-1];

endmodule

[rtl/bptc_front.sv]
module bptc_front #(
  parameter int ADC_BITS = 24
) (
  input  logic                  clk_i,
  input  logic [2:0]            en_i,
  input  bptc_pkg::in_t         in_i,
  input  bptc_pkg::cfg_t        cfg_i,
  output bptc_pkg::front_t      res_o
);

  localparam int RawW = bptc_pkg::RawW;
  localparam logic [RawW-1:0] AdcMask =
    RawW'(({1'b0, {RawW{1'b1}}}) >> (RawW - ADC_BITS));

  // stage 0: masked readings, dT
  logic [RawW-1:0]    d1_0_q;
  logic signed [24:0] dt_0_q, dt_d;

  assign dt_d = $signed({1'b0, in_i.raw_temperature & AdcMask})
              - $signed({1'b0, cfg_i.ref_temp_coeff, 8'b0});

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      d1_0_q <= in_i.raw_pressure & AdcMask;
      dt_0_q <= dt_d;
    end
  end

  // stage 1: the four dT products
  logic [RawW-1:0]    d1_1_q;
  logic signed [41:0] p_ts_q, p_o_q, p_s_q;
  logic signed [41:0] p_ts_d, p_o_d, p_s_d;
  logic signed [49:0] p_dd_q, p_dd_d;

  assign p_ts_d = dt_0_q * $signed({1'b0, cfg_i.temp_slope_coeff});
  assign p_o_d  = dt_0_q * $signed({1'b0, cfg_i.offset_temp_coeff});
  assign p_s_d  = dt_0_q * $signed({1'b0, cfg_i.sens_temp_coeff});
  assign p_dd_d = dt_0_q * dt_0_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      d1_1_q <= d1_0_q;
      p_ts_q <= p_ts_d;
      p_o_q  <= p_o_d;
      p_s_q  <= p_s_d;
      p_dd_q <= p_dd_d;
    end
  end

  // stage 2: first-order TEMP, OFF, SENS and T2
  bptc_pkg::front_t res_q;
  logic signed [19:0] temp_d;
  logic signed [35:0] off_d;
  logic signed [34:0] sens_d;

  assign temp_d = 20'(p_ts_q >>> 23) + 20'sd2000;
  assign off_d  = $signed({4'b0, cfg_i.offset_coeff, 16'b0}) + 36'(p_o_q >>> 7);
  assign sens_d = $signed({4'b0, cfg_i.sens_coeff, 15'b0}) + 35'(p_s_q >>> 8);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      res_q.d1   <= d1_1_q;
      res_q.temp <= temp_d;
      res_q.off  <= off_d;
      res_q.sens <= sens_d;
      res_q.t2   <= p_dd_q[48:31];
    end
  end

  assign res_o = res_q;

endmodule

[rtl/bptc_corr.sv]
module bptc_corr (
  input  logic              clk_i,
  input  logic [2:0]        en_i,
  input  bptc_pkg::front_t  front_i,
  output bptc_pkg::corr_t   res_o
);

  // stage 3: squares for the low-temperature correction
  logic signed [19:0] temp;
  logic signed [20:0] ta, tb, tc_d;
  logic signed [41:0] a_sq, b_sq;
  logic               lt_d, lt15_d;

  assign temp   = front_i.temp;
  assign ta     = temp - 21'sd2000;
  assign tb     = temp + 21'sd1500;
  assign a_sq   = ta * ta;
  assign b_sq   = tb * tb;
  assign lt_d   = temp < 20'sd2000;
  assign lt15_d = temp < -20'sd1500;
  assign tc_d   = lt_d ? temp - $signed({1'b0, front_i.t2}) : temp;

  logic [23:0]        d1_3_q;
  logic [34:0]        a_3_q, b_3_q;
  logic               lt_3_q, lt15_3_q;
  logic signed [20:0] tc_3_q;
  logic signed [35:0] off_3_q;
  logic signed [34:0] sens_3_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      d1_3_q   <= front_i.d1;
      a_3_q    <= a_sq[34:0];
      b_3_q    <= b_sq[34:0];
      lt_3_q   <= lt_d;
      lt15_3_q <= lt15_d;
      tc_3_q   <= tc_d;
      off_3_q  <= front_i.off;
      sens_3_q <= front_i.sens;
    end
  end

  // stage 4: OFF2, SENS2 by shift-add; clip temperature
  logic [37:0] a5, b7, b11, off2_d, sens2_d;
  logic signed [15:0] tout_d;
  logic               tsat_d;

  assign a5  = ({3'b0, a_3_q} << 2) + {3'b0, a_3_q};
  assign b7  = ({3'b0, b_3_q} << 3) - {3'b0, b_3_q};
  assign b11 = ({3'b0, b_3_q} << 3) + ({3'b0, b_3_q} << 1) + {3'b0, b_3_q};

  always_comb begin
    off2_d  = '0;
    sens2_d = '0;
    if (lt_3_q) begin
      off2_d  = a5 >> 1;
      sens2_d = a5 >> 2;
      if (lt15_3_q) begin
        off2_d  = (a5 >> 1) + b7;
        sens2_d = (a5 >> 2) + (b11 >> 1);
      end
    end
  end

  always_comb begin
    tsat_d = 1'b1;
    if (tc_3_q > 21'sd32767) begin
      tout_d = 16'sh7FFF;
    end else if (tc_3_q < -21'sd32768) begin
      tout_d = 16'sh8000;
    end else begin
      tout_d = tc_3_q[15:0];
      tsat_d = 1'b0;
    end
  end

  logic [23:0]        d1_4_q;
  logic [37:0]        off2_4_q, sens2_4_q;
  logic signed [35:0] off_4_q;
  logic signed [34:0] sens_4_q;
  logic signed [15:0] tout_4_q;
  logic               tsat_4_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      d1_4_q    <= d1_3_q;
      off2_4_q  <= off2_d;
      sens2_4_q <= sens2_d;
      off_4_q   <= off_3_q;
      sens_4_q  <= sens_3_q;
      tout_4_q  <= tout_d;
      tsat_4_q  <= tsat_d;
    end
  end

  // stage 5: OFF' and SENS'
  bptc_pkg::corr_t    res_q;
  logic signed [39:0] offc_d, sensc_d;

  assign offc_d  = off_4_q - $signed({2'b0, off2_4_q});
  assign sensc_d = sens_4_q - $signed({2'b0, sens2_4_q});

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      res_q.d1          <= d1_4_q;
      res_q.offc        <= offc_d;
      res_q.sensc       <= sensc_d;
      res_q.temperature <= tout_4_q;
      res_q.tsat        <= tsat_4_q;
    end
  end

  assign res_o = res_q;

endmodule

[rtl/bptc_press.sv]
module bptc_press (
  input  logic              clk_i,
  input  logic [3:0]        en_i,
  input  bptc_pkg::corr_t   corr_i,
  output bptc_pkg::out_t    res_o
);

  // stage 6: D1 * SENS' as two partial products
  logic [43:0]        pp_lo_d, pp_lo_q;
  logic signed [44:0] pp_hi_d, pp_hi_q;
  logic signed [39:0] offc_6_q;
  logic signed [15:0] tout_6_q;
  logic               tsat_6_q;

  assign pp_lo_d = corr_i.d1 * corr_i.sensc[19:0];
  assign pp_hi_d = $signed({1'b0, corr_i.d1}) * $signed(corr_i.sensc[39:20]);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pp_lo_q  <= pp_lo_d;
      pp_hi_q  <= pp_hi_d;
      offc_6_q <= corr_i.offc;
      tout_6_q <= corr_i.temperature;
      tsat_6_q <= corr_i.tsat;
    end
  end

  // stage 7: recombine
  logic signed [63:0] hi_ext, prod_d, prod_q;
  logic signed [39:0] offc_7_q;
  logic signed [15:0] tout_7_q;
  logic               tsat_7_q;

  assign hi_ext = pp_hi_q;
  assign prod_d = (hi_ext <<< 20) + $signed({20'b0, pp_lo_q});

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      prod_q   <= prod_d;
      offc_7_q <= offc_6_q;
      tout_7_q <= tout_6_q;
      tsat_7_q <= tsat_6_q;
    end
  end

  // stage 8: (D1*SENS' >> 21) - OFF'
  logic signed [43:0] prod_sh, x_d, x_q;
  logic signed [15:0] tout_8_q;
  logic               tsat_8_q;

  assign prod_sh = 44'(prod_q >>> 21);
  assign x_d     = prod_sh - offc_7_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      x_q      <= x_d;
      tout_8_q <= tout_7_q;
      tsat_8_q <= tsat_7_q;
    end
  end

  // stage 9: >> 15, clip, output register
  logic signed [28:0] p;
  logic [17:0]        pres_d;
  logic               psat_d;
  bptc_pkg::out_t     res_q;

  assign p = 29'(x_q >>> 15);

  always_comb begin
    psat_d = 1'b1;
    if (p < 29'sd0) begin
      pres_d = '0;
    end else if (p > 29'sd262143) begin
      pres_d = '1;
    end else begin
      pres_d = p[17:0];
      psat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      res_q.temperature <= tout_8_q;
      res_q.pressure    <= pres_d;
      res_q.saturated   <= tsat_8_q | psat_d;
    end
  end

  assign res_o = res_q;

endmodule

[rtl/bptc_checker.sv]
module bptc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input bptc_pkg::in_t                in_data_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input bptc_pkg::out_t               out_data_o,
  input logic                         cfg_we_i,
  input logic [bptc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input logic [bptc_pkg::CoeffW-1:0]  cfg_wdata_i
);

  // a held result keeps its beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // with the sink open the pipeline always takes a reading
  a_no_stall_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled with output side open");

  // nothing comes out of reset
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

  // an accepted reading reaches the output when the sink is never stalled
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_stall_i) ##1 !out_stall_i ##1 !out_stall_i
    ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
    ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("reading did not arrive after ten open cycles");

endmodule

bind baro_pressure_temp_compensation_top bptc_checker u_bptc_checker (.*);

[sim/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bptc_pkg::*;

  localparam int AdcBits = 24;
  localparam logic [RawW-1:0] AdcMask = RawW'((64'd1 << AdcBits) - 1);
  localparam int PipeDepth = NumStages;
  localparam int QuietLimit = 2000;
  localparam int NumPhases = 6;
  localparam int BeatsPerPhase = 67;
  localparam int NumRows = 20;

  // indexes past the last register; writes there must be dropped
  localparam logic [CfgIdxW-1:0] RegSpareA = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareB = 3'd7;
  localparam logic [CfgIdxW-1:0] WriteOrder [8] = '{
    RegSensCoeff, RegOffsetCoeff, RegSpareA, RegSensTempCoeff,
    RegOffsetTempCoeff, RegRefTempCoeff, RegSpareB, RegTempSlopeCoeff
  };

  // sens, offset, sens_temp, offset_temp, ref_temp, temp_slope
  localparam cfg_t CalZero = '0;
  localparam cfg_t CalMax = '1;
  localparam cfg_t CalTyp = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
  localparam cfg_t CalHot = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF};

  localparam out_t OutNone = '0;
  // zero calibration: dT is ignored, TEMP stays at 20.00 degC, pressure 0
  localparam out_t OutRoom = '{16'sd2000, 18'd0, 1'b0};
  localparam out_t OutClip = '{16'sd32767, 18'h3FFFF, 1'b1};

  typedef struct packed {
    cfg_t            cal;
    logic [RawW-1:0] rp;
    logic [RawW-1:0] rt;
    logic            typed;
    out_t            want;
  } dir_row_t;

  localparam dir_row_t DirRows [NumRows] = '{
    '{CalZero, 24'h000000, 24'h000000, 1'b1, OutRoom},
    '{CalZero, 24'hFFFFFF, 24'hFFFFFF, 1'b1, OutRoom},
    '{CalZero, 24'hFFFFFF, 24'h000000, 1'b1, OutRoom},
    '{CalZero, 24'h000000, 24'hFFFFFF, 1'b1, OutRoom},
    '{CalZero, 24'hAAAAAA, 24'h555555, 1'b1, OutRoom},
    // typical part: room temp, TEMP exactly 2000 and 1999, -15.00 boundary, deep cold
    '{CalTyp, 24'd9085466, 24'd8569150, 1'b0, OutNone},
    '{CalTyp, 24'd9085466, 24'd8566784, 1'b0, OutNone},
    '{CalTyp, 24'd9085466, 24'd8566783, 1'b0, OutNone},
    '{CalTyp, 24'd9085466, 24'd7529764, 1'b0, OutNone},
    '{CalTyp, 24'd9085466, 24'd7529763, 1'b0, OutNone},
    '{CalTyp, 24'd9085466, 24'd6000000, 1'b0, OutNone},
    '{CalTyp, 24'h000000, 24'd8569150, 1'b0, OutNone},
    '{CalTyp, 24'hFFFFFF, 24'd8569150, 1'b0, OutNone},
    '{CalTyp, 24'hFFFFFF, 24'h000000, 1'b0, OutNone},
    '{CalMax, 24'hFFFFFF, 24'hFFFFFF, 1'b0, OutNone},
    '{CalMax, 24'hFFFFFF, 24'h000000, 1'b0, OutNone},
    '{CalMax, 24'h000000, 24'h000000, 1'b0, OutNone},
    // hot calibration: the first row clips both outputs high
    '{CalHot, 24'hFFFFFF, 24'hFFFFFF, 1'b1, OutClip},
    '{CalHot, 24'hFFFFFF, 24'h000000, 1'b0, OutNone},
    '{CalHot, 24'h000000, 24'hFFFFFF, 1'b0, OutNone}
  };

  typedef enum logic [1:0] {StallNone, StallLight, StallHeavy, StallPeriodic} stall_mode_e;
  typedef enum logic [1:0] {CalNearTyp, CalRandom, CalAllMax, CalAllZero} cal_mode_e;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CoeffW-1:0] cfg_wdata_i = '0;

  // typed expectation riding along with the beat on the input
  logic row_typed = 1'b0;
  out_t row_want = '0;

  cfg_t calib = '0;
  out_t pending_readouts [$];
  int err_cnt = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  stall_mode_e stall_mode = StallNone;
  int stall_left = 0;

  cal_mode_e cal_mode;
  cfg_t next_cal;
  in_t beat;
  longint t_center;
  longint t_raw;
  int pick;

  baro_pressure_temp_compensation_top #(
    .ADC_BITS(AdcBits)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic out_t compensate_reading(in_t rd, cfg_t c);
    longint d1, d2, dt, tc, off, sens, t2, off2, sens2, a, b, p;
    logic clip;
    out_t r;
    d1 = longint'(rd.raw_pressure & AdcMask);
    d2 = longint'(rd.raw_temperature & AdcMask);
    dt = d2 - (longint'(c.ref_temp_coeff) <<< 8);
    tc = 2000 + ((dt * longint'(c.temp_slope_coeff)) >>> 23);
    off = (longint'(c.offset_coeff) <<< 16) + ((longint'(c.offset_temp_coeff) * dt) >>> 7);
    sens = (longint'(c.sens_coeff) <<< 15) + ((longint'(c.sens_temp_coeff) * dt) >>> 8);
    t2 = 0;
    off2 = 0;
    sens2 = 0;
    if (tc < 2000) begin
      a = (tc - 2000) * (tc - 2000);
      t2 = (dt * dt) >>> 31;
      off2 = (5 * a) >>> 1;
      sens2 = (5 * a) >>> 2;
      if (tc < -1500) begin
        b = (tc + 1500) * (tc + 1500);
        off2 += 7 * b;
        sens2 += (11 * b) >>> 1;
      end
    end
    tc -= t2;
    off -= off2;
    sens -= sens2;
    p = (((d1 * sens) >>> 21) - off) >>> 15;
    clip = 1'b0;
    if (tc > 32767) begin
      tc = 32767;
      clip = 1'b1;
    end
    if (tc < -32768) begin
      tc = -32768;
      clip = 1'b1;
    end
    if (p > 262143) begin
      p = 262143;
      clip = 1'b1;
    end
    if (p < 0) begin
      p = 0;
      clip = 1'b1;
    end
    r.temperature = tc[15:0];
    r.pressure = p[17:0];
    r.saturated = clip;
    return r;
  endfunction

  // receiver stall pattern: segments of random length, each with its own mode
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(8, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      StallNone:     out_stall_i <= 1'b0;
      StallLight:    out_stall_i <= ($urandom_range(0, 3) == 0);
      StallHeavy:    out_stall_i <= ($urandom_range(0, 3) != 0);
      StallPeriodic: out_stall_i <= stall_left[2];
      default:       out_stall_i <= 1'b0;
    endcase
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pending_readouts.push_back(row_typed ? row_want : compensate_reading(in_data_i, calib));
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_readouts.size() == 0) begin
          $error("result beat with nothing expected: temperature %0d pressure %0d",
                 out_data_o.temperature, out_data_o.pressure);
          err_cnt++;
        end else begin
          want = pending_readouts.pop_front();
          if (out_data_o.temperature !== want.temperature) begin
            $error("temperature: expected %0d, got %0d", want.temperature,
                   out_data_o.temperature);
            err_cnt++;
          end
          if (out_data_o.pressure !== want.pressure) begin
            $error("pressure: expected %0d, got %0d", want.pressure, out_data_o.pressure);
            err_cnt++;
          end
          if (out_data_o.saturated !== want.saturated) begin
            $error("saturated: expected %0d, got %0d", want.saturated, out_data_o.saturated);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("baro_pressure_temp_compensation_top test failed");
        $finish;
      end
    end
  end

  task automatic send_reading(input in_t rd, input logic typed, input out_t want);
    in_valid_i <= 1'b1;
    in_data_i <= rd;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk_i); while (in_stall_o);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  // hold off the sender until the pipe has handed back every result
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_readouts.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_calib(input cfg_t c);
    logic [CfgIdxW-1:0] idx;
    logic [CoeffW-1:0] val;
    for (int i = 0; i < 8; i++) begin
      idx = WriteOrder[i];
      case (idx)
        RegSensCoeff:       val = c.sens_coeff;
        RegOffsetCoeff:     val = c.offset_coeff;
        RegSensTempCoeff:   val = c.sens_temp_coeff;
        RegOffsetTempCoeff: val = c.offset_temp_coeff;
        RegRefTempCoeff:    val = c.ref_temp_coeff;
        RegTempSlopeCoeff:  val = c.temp_slope_coeff;
        default:            val = CoeffW'($urandom);
      endcase
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx;
      cfg_wdata_i <= val;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    calib = c;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      if (DirRows[i].cal != calib) begin
        drain_pipe();
        load_calib(DirRows[i].cal);
      end
      beat.raw_pressure = DirRows[i].rp;
      beat.raw_temperature = DirRows[i].rt;
      send_reading(beat, DirRows[i].typed, DirRows[i].want);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      cal_mode = cal_mode_e'(ph % 4);
      case (cal_mode)
        CalNearTyp: next_cal = CalTyp ^ (cfg_t'({$urandom, $urandom, $urandom}) & {6{16'h0FFF}});
        CalRandom:  next_cal = cfg_t'({$urandom, $urandom, $urandom});
        CalAllMax:  next_cal = CalMax;
        default:    next_cal = CalZero;
      endcase
      drain_pipe();
      load_calib(next_cal);
      for (int n = 0; n < BeatsPerPhase; n++) begin
        pick = $urandom_range(0, 9);
        beat.raw_pressure = RawW'($urandom);
        beat.raw_temperature = RawW'($urandom);
        if (pick <= 5) begin
          // temperature reading around the reference point: covers warm, cold and deep cold
          t_center = longint'(calib.ref_temp_coeff) <<< 8;
          t_raw = t_center + longint'($urandom_range(0, 32'h3FFFFF)) - 64'sh200000;
          if (t_raw < 0) t_raw = 0;
          if (t_raw > 64'hFFFFFF) t_raw = 64'hFFFFFF;
          beat.raw_temperature = t_raw[RawW-1:0];
        end else if (pick == 9) begin
          if ($urandom_range(0, 1) == 1) beat.raw_pressure = {RawW{$urandom_range(0, 1) == 1}};
          if ($urandom_range(0, 1) == 1) begin
            beat.raw_temperature = {RawW{$urandom_range(0, 1) == 1}};
          end
        end
        send_reading(beat, 1'b0, OutNone);
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_readouts.size() != 0) @(posedge clk_i);
    repeat (2 * PipeDepth) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("baro_pressure_temp_compensation_top test passed");
    end else begin
      $display("baro_pressure_temp_compensation_top test failed");
    end
    $finish;
  end

endmodule
